// File: design/bfkf_pkg.sv
// ----------------------------------------------------------------------------
// Band filtered kth farthest package
// Shared widths, register codes and link types for the selection block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfkf_pkg;

  localparam int MAX_RANK   = 16;
  localparam int CNT_W      = $clog2(MAX_RANK + 1);
  localparam int RANK_W     = 5;
  localparam int SEL_W      = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int COORD_W    = 32;
  localparam int VAL_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Center sum: 96 bits with 56 fractional bits, then the band difference.
  localparam int SUM_W      = 96;
  localparam int FRAC       = 56;
  localparam int CTR_W      = SUM_W - FRAC;
  localparam int DY_W       = CTR_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_CURVATURE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANK           = 3'd4;

  // Candidate word handed from the corridor filter to the sorted chain.
  typedef struct packed {
    logic             push;
    logic             last;
    logic [VAL_W-1:0] value;
  } cand_t;

  // What one chain cell shows to its right-hand neighbor.
  typedef struct packed {
    logic             ins;
    logic             valid;
    logic [VAL_W-1:0] value;
  } link_t;

endpackage

`default_nettype wire

// File: design/band_filtered_kth_farthest_unit.sv
// ----------------------------------------------------------------------------
// Band filtered kth farthest unit
// Reports the rank-th farthest point of a cloud inside a curved corridor.
// ----------------------------------------------------------------------------
// Points enter on the point channel (point_valid / point_stall), one word per
// cycle. A word with has_point set carries a point; a word with last set ends
// the cloud. Points with positive forward position inside the corridor around
// center_offset + slope*x + half_curvature*x*x are kept in a chain of sorted
// cells. One result word leaves on the result channel per cloud. The accepting
// edge loads the first of six center and band stages; the chain insert and the
// output register follow in that order before result_valid rises. Throughput
// is one word per cycle. While a result word waits under result_stall, the
// whole pipeline freezes and point_stall is raised. Reset clears the pipeline,
// the chain and the registers (rank returns to one). The user must write the
// registers on the cfg port only while no cloud is in flight; the block does
// not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module band_filtered_kth_farthest_unit import bfkf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      point_valid,
  output logic                      point_stall,
  input  logic                      has_point,
  input  logic signed [COORD_W-1:0] x_pos,
  input  logic signed [COORD_W-1:0] y_pos,
  input  logic                      last,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [VAL_W-1:0]          distance,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic signed [31:0] center_offset;
  logic signed [31:0] slope;
  logic signed [31:0] half_curvature;
  logic [30:0]        band_width;
  logic [RANK_W-1:0]  rank;

  logic               adv;
  logic               accept;
  cand_t              cand;
  logic               emit;
  logic [VAL_W-1:0]   pick;

  assign adv         = !(result_valid && result_stall);
  assign point_stall = !adv;
  assign accept      = point_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset  <= '0;
      slope          <= '0;
      half_curvature <= '0;
      band_width     <= '0;
      rank           <= RANK_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_OFFSET:  center_offset  <= $signed(cfg_data);
        REG_SLOPE:          slope          <= $signed(cfg_data);
        REG_HALF_CURVATURE: half_curvature <= $signed(cfg_data);
        REG_BAND_WIDTH:     band_width     <= cfg_data[30:0];
        REG_RANK:           rank           <= cfg_data[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  bfkf_band u_band (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .accept         (accept),
    .has_point      (has_point),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .last           (last),
    .center_offset  (center_offset),
    .slope          (slope),
    .half_curvature (half_curvature),
    .band_width     (band_width),
    .cand           (cand)
  );

  bfkf_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .cand (cand),
    .rank (rank),
    .emit (emit),
    .pick (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      distance <= pick;
    end
  end

endmodule

`default_nettype wire

// File: design/bfkf_cell.sv
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one kept value; takes the new word or its left neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module bfkf_cell import bfkf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             clear,
  input  logic             push,
  input  logic [VAL_W-1:0] word,
  input  link_t            left,
  output link_t            right
);

  logic             valid;
  logic [VAL_W-1:0] value;
  logic             live;
  logic             ins;

  // A cell clears together with the whole chain at the end of a cloud.
  assign live  = valid && !clear;
  assign ins   = push && (!live || (word > value));
  assign right = '{ins: ins, valid: live, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      if (ins) begin
        valid <= left.ins ? left.valid : 1'b1;
      end else begin
        valid <= live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ins) begin
      value <= left.ins ? left.value : word;
    end
  end

endmodule

`default_nettype wire

// File: design/bfkf_chain.sv
// ----------------------------------------------------------------------------
// Sorted insertion chain
// Keeps the largest kept values in descending order and picks the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfkf_chain import bfkf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cand_t             cand,
  input  logic [RANK_W-1:0] rank,
  output logic              emit,
  output logic [VAL_W-1:0]  pick
);

  link_t            links [MAX_RANK+1];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] count_next;
  logic             flush;
  logic [SEL_W-1:0] r_ext;
  logic [SEL_W-1:0] r_eff;
  logic [SEL_W-1:0] cnt_ext;
  logic [SEL_W-1:0] sel;

  assign links[0] = '{ins: 1'b0, valid: 1'b1, value: cand.value};

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    bfkf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .clear (flush),
      .push  (cand.push),
      .word  (cand.value),
      .left  (links[i]),
      .right (links[i+1])
    );
  end

  // A push into a chain that is not full always lands somewhere.
  assign base       = flush ? '0 : count;
  assign count_next = (cand.push && (base != CNT_W'(MAX_RANK))) ? base + 1'b1 : base;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      flush <= 1'b0;
    end else if (en) begin
      count <= count_next;
      flush <= cand.last;
    end
  end

  // The result is read while the flush flag registered from the last word is high, before clearing.
  // Cell k shows its value on link k+1, so the selected position is the link.
  always_comb begin
    r_ext   = SEL_W'(rank);
    cnt_ext = SEL_W'(count);
    if (r_ext == '0) begin
      r_eff = SEL_W'(1);
    end else if (r_ext > SEL_W'(MAX_RANK)) begin
      r_eff = SEL_W'(MAX_RANK);
    end else begin
      r_eff = r_ext;
    end
    sel = (cnt_ext >= r_eff) ? r_eff : cnt_ext;
    if (count == '0) begin
      pick = '0;
    end else begin
      pick = links[sel].value;
    end
  end

  assign emit = flush;

endmodule

`default_nettype wire

// File: design/bfkf_band.sv
// ----------------------------------------------------------------------------
// Corridor filter pipeline
// Computes the track center at the point's forward position and tests the band.
// ----------------------------------------------------------------------------
`default_nettype none

module bfkf_band import bfkf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      accept,
  input  logic                      has_point,
  input  logic signed [COORD_W-1:0] x_pos,
  input  logic signed [COORD_W-1:0] y_pos,
  input  logic                      last,
  input  logic signed [31:0]        center_offset,
  input  logic signed [31:0]        slope,
  input  logic signed [31:0]        half_curvature,
  input  logic [30:0]               band_width,
  output cand_t                     cand
);

  typedef struct packed {
    logic vld;
    logic cand;
    logic last;
  } tag_t;

  tag_t tag1, tag2, tag3, tag4, tag5, tag6;

  logic signed [COORD_W-1:0] x1, x2;
  logic [VAL_W-1:0]          x3, x4, x5, x6;
  logic signed [COORD_W-1:0] y1, y2, y3, y4, y5;
  logic signed [63:0]        sx1, hx1, mhi2;
  logic [62:0]               mlo2;
  logic signed [SUM_W-1:0]   lin2, lin3, cq3, sum4;
  logic signed [CTR_W-1:0]   center4;
  logic signed [DY_W-1:0]    dy5, bnd, neg_bnd;
  logic                      keep6;

  assign sum4    = cq3 + lin3;
  assign bnd     = $signed({(DY_W-31)'(0), band_width});
  assign neg_bnd = -bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
      tag5 <= '0;
      tag6 <= '0;
    end else if (en) begin
      tag1 <= '{vld: accept,
                cand: has_point && !x_pos[COORD_W-1] && (x_pos != '0),
                last: last};
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
      tag5 <= tag4;
      tag6 <= tag5;
    end
  end

  // The curvature term hc*x*x is split into low and high halves of hc*x;
  // only points with a positive forward coordinate are kept.
  always_ff @(posedge clk) begin
    if (en) begin
      x1      <= x_pos;
      y1      <= y_pos;
      sx1     <= slope * x_pos;
      hx1     <= half_curvature * x_pos;
      x2      <= x1;
      y2      <= y1;
      mlo2    <= hx1[31:0] * x1[30:0];
      mhi2    <= $signed(hx1[63:32]) * x1;
      lin2    <= $signed({{8{center_offset[31]}}, center_offset, 56'd0})
               + $signed({{4{sx1[63]}}, sx1, 28'd0});
      x3      <= x2[VAL_W-1:0];
      y3      <= y2;
      cq3     <= $signed({mhi2, 32'd0}) + $signed({33'd0, mlo2});
      lin3    <= lin2;
      x4      <= x3;
      y4      <= y3;
      center4 <= sum4[SUM_W-1:FRAC];
      x5      <= x4;
      y5      <= y4;
      dy5     <= $signed({{(DY_W-COORD_W){y4[COORD_W-1]}}, y4})
               - $signed({{(DY_W-CTR_W){center4[CTR_W-1]}}, center4});
      x6      <= x5;
      keep6   <= (dy5 < bnd) && (dy5 > neg_bnd);
    end
  end

  assign cand = '{push: tag6.vld && tag6.cand && keep6,
                  last: tag6.vld && tag6.last,
                  value: x6};

endmodule

`default_nettype wire

// File: design/bfkf_checker.sv
// ----------------------------------------------------------------------------
// Band filtered kth farthest checker
// Port-level checks on reset, result holding and input backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module bfkf_checker import bfkf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             point_stall,
  input logic             result_valid,
  input logic             result_stall,
  input logic [VAL_W-1:0] distance
);

  // No result word may come straight out of reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word present after reset");

  // A stalled result word stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(distance)))
    else $error("stalled result word changed");

  // A waiting result word freezes the input side.
  a_input_blocked: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> point_stall)
    else $error("point word accepted while result word is stalled");

  // Results come only from a cloud end, which needs accepted words first.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    ($rose(result_valid) && !$past(rst)) |-> !$past(point_stall))
    else $error("result word appeared while the pipeline was frozen");

endmodule

bind band_filtered_kth_farthest_unit bfkf_checker u_bfkf_checker (.*);

`default_nettype wire

// File: sim/band_filtered_kth_farthest_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Band filtered kth farthest unit testbench
// Streams point clouds through the unit under several corridor and rank
// settings, predicts each cloud's selected distance and checks every result
// word against it, with random idling on both channels.
// ----------------------------------------------------------------------------

module band_filtered_kth_farthest_unit_tb;
  import bfkf_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS  = 148;

  // Tracks corridor settings and the sorted list of farthest kept points.
  class kth_scoreboard;
    logic signed [31:0] ctr_off;
    logic signed [31:0] slope_q28;
    logic signed [31:0] half_curv;
    logic [30:0]        band;
    logic [4:0]         rank_reg;
    logic [31:0]        farthest [MAX_RANK];
    int unsigned        held;
    logic [VAL_W-1:0]   expected_dist [$];
    int                 errors;

    function new();
      ctr_off   = '0;
      slope_q28 = '0;
      half_curv = '0;
      band      = '0;
      rank_reg  = 5'd1;
      held      = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_OFFSET:  ctr_off   = data;
        REG_SLOPE:          slope_q28 = data;
        REG_HALF_CURVATURE: half_curv = data;
        REG_BAND_WIDTH:     band      = data[30:0];
        REG_RANK:           rank_reg  = data[4:0];
        default: ;
      endcase
    endfunction

    // Exact sum with 56 fractional bits, floored back to Q16.16.
    function longint corridor_center(logic signed [31:0] x);
      logic signed [127:0] xw, cw, sw, hw, acc;
      xw  = x;
      cw  = ctr_off;
      sw  = slope_q28;
      hw  = half_curv;
      acc = (cw <<< 56) + ((sw * xw) <<< 28) + hw * xw * xw;
      return longint'(acc >>> 56);
    endfunction

    function void keep_point(logic [31:0] v);
      int unsigned pos, i;
      pos = 0;
      while (pos < held && farthest[pos] >= v) pos++;
      if (pos >= MAX_RANK) return;
      if (held < MAX_RANK) held++;
      for (i = held - 1; i > pos; i--) farthest[i] = farthest[i-1];
      farthest[pos] = v;
    endfunction

    function void note_word(logic hp, logic signed [31:0] x, logic signed [31:0] y,
                            logic lst);
      longint      dy;
      int unsigned sel;
      logic [31:0] pick;
      if (hp && x > 0) begin
        dy = longint'(y) - corridor_center(x);
        if (dy < 0) dy = -dy;
        if (dy < longint'(band)) keep_point(x);
      end
      if (lst) begin
        sel = rank_reg;
        if (sel == 0) sel = 1;
        if (sel > MAX_RANK) sel = MAX_RANK;
        if (held == 0) pick = '0;
        else if (held >= sel) pick = farthest[sel-1];
        else pick = farthest[held-1];
        expected_dist = {expected_dist, pick[VAL_W-1:0]};
        held = 0;
      end
    endfunction

    function void check_result(logic [VAL_W-1:0] dist_out);
      logic [VAL_W-1:0] want;
      if (expected_dist.size() == 0) begin
        $error("distance: no word expected, actual %0d", dist_out);
        errors++;
      end else begin
        want = expected_dist.pop_front();
        if (want !== dist_out) begin
          $error("distance: expected %0d, actual %0d", want, dist_out);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_dist.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      point_valid;
  logic                      point_stall;
  logic                      has_point;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] y_pos;
  logic                      last;
  logic                      result_valid;
  logic                      result_stall;
  logic [VAL_W-1:0]          distance;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  int src_idle_pct = 14;
  int dst_idle_pct = 54;

  kth_scoreboard sb = new();

  band_filtered_kth_farthest_unit dut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .has_point    (has_point),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .distance     (distance),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < dst_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && !point_stall) sb.note_word(has_point, x_pos, y_pos, last);
      if (result_valid && !result_stall) sb.check_result(distance);
    end
  end

  task automatic send_word(logic hp, logic signed [31:0] x, logic signed [31:0] y,
                           logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    has_point   <= hp;
    x_pos       <= x;
    y_pos       <= y;
    last        <= lst;
    do @(posedge clk); while (point_stall);
  endtask

  // Holds the sender until every expected word is back and the pipe is empty.
  task automatic settle();
    point_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] c, logic [31:0] s, logic [31:0] h,
                              logic [31:0] b, logic [31:0] r);
    write_reg(REG_CENTER_OFFSET, c);
    write_reg(REG_SLOPE, s);
    write_reg(REG_HALF_CURVATURE, h);
    write_reg(REG_BAND_WIDTH, b);
    write_reg(REG_RANK, r);
    cfg_write <= 1'b0;
  endtask

  task automatic program_random();
    logic [31:0] c, s, h, b;
    logic [4:0]  r;
    c = $urandom;
    case ($urandom_range(2))
      0: begin
        s = '0;
        h = '0;
      end
      1: begin
        s = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        h = $urandom_range(0, 32'h1000) - 32'h800;
      end
      default: begin
        s = $urandom;
        h = $urandom;
      end
    endcase
    case ($urandom_range(3))
      0:       b = 32'h7FFF_FFFF;
      1:       b = $urandom_range(1, 32'h0001_0000);
      default: b = $urandom_range(32'h0001_0000, 32'h0400_0000);
    endcase
    b[31] = $urandom_range(1);
    case ($urandom_range(5))
      0:       r = 5'd0;
      1:       r = 5'd1;
      2:       r = 5'd16;
      3:       r = $urandom_range(17, 31);
      default: r = $urandom_range(2, 15);
    endcase
    program_regs(c, s, h, b, {($urandom_range(1) ? 27'($urandom) : 27'd0), r});
  endtask

  function automatic logic signed [31:0] pick_x();
    case ($urandom_range(9))
      0:       return 32'sd0;
      1:       return $urandom | 32'h8000_0000;
      2, 3:    return $urandom_range(1, 40);
      4:       return 32'h7FFF_FFFF;
      5, 6:    return $urandom_range(1, 32'h00FF_FFFF);
      default: return $urandom_range(1, 32'h7FFF_FFFF);
    endcase
  endfunction

  // Mostly lands inside the corridor, sometimes right on its edge.
  function automatic logic signed [31:0] pick_y(logic signed [31:0] x);
    longint      d, yl;
    logic [30:0] bw;
    bw = sb.band;
    if (x <= 0 || $urandom_range(7) == 0) return $urandom;
    case ($urandom_range(9))
      0: d = longint'(bw);
      1: d = -longint'(bw);
      2: d = longint'(bw) - 1;
      3: d = 1 - longint'(bw);
      default: begin
        d = longint'({32'd0, $urandom}) % (longint'(bw) + 1);
        if ($urandom_range(1)) d = -d;
      end
    endcase
    yl = sb.corridor_center(x) + d;
    return yl[31:0];
  endfunction

  task automatic send_cloud(inout int counted);
    int                 npts, i;
    logic               end_on_point;
    logic signed [31:0] x;
    npts = ($urandom_range(9) == 0) ? $urandom_range(17, 36) : $urandom_range(0, 14);
    end_on_point = (npts > 0) && $urandom_range(1);
    for (i = 0; i < npts; i++) begin
      if ($urandom_range(9) == 0) begin
        send_word(1'b0, $urandom, $urandom, 1'b0);
        counted++;
      end
      x = pick_x();
      send_word(1'b1, x, pick_y(x), end_on_point && (i == npts - 1));
      counted++;
    end
    if (!end_on_point) begin
      send_word(1'b0, $urandom, $urandom, 1'b1);
      counted++;
    end
  endtask

  initial begin
    int mode, phase, counted;
    rst          <= 1'b1;
    point_valid  <= 1'b0;
    has_point    <= 1'b0;
    x_pos        <= '0;
    y_pos        <= '0;
    last         <= 1'b0;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_CENTER_OFFSET;
    cfg_data     <= '0;
    result_stall <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Open corridor, rank one: empty cloud, extreme point, edges of the band.
    program_regs(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd1);
    send_word(1'b0, 32'sd0, 32'sd0, 1'b1);
    send_word(1'b1, 32'h7FFF_FFFF, 32'sd0, 1'b1);
    send_word(1'b1, 32'sd0, 32'sd0, 1'b0);
    send_word(1'b1, 32'h8000_0000, 32'sd0, 1'b0);
    send_word(1'b1, 32'h0005_0000, 32'h8000_0000, 1'b0);
    send_word(1'b1, 32'h0006_0000, 32'h7FFF_FFFF, 1'b0);
    send_word(1'b1, 32'sd1, 32'h7FFF_FFFE, 1'b0);
    send_word(1'b0, 32'h0009_0000, 32'sd0, 1'b1);
    settle();

    // Extreme track terms with rank zero.
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_word(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_word(1'b1, 32'h0001_0000, pick_y(32'h0001_0000), 1'b0);
    send_word(1'b1, 32'sd1, 32'h8000_0000, 1'b1);
    settle();

    // Zero band keeps nothing.
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd17);
    send_word(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_word(1'b1, 32'sd1, 32'h7FFF_FFFF, 1'b1);
    settle();

    // Rank beyond the chain depth with fewer points kept, then a tie.
    program_regs(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(1'b1, 32'sd7, 32'sd0, 1'b0);
    send_word(1'b1, 32'sd7, 32'sd0, 1'b0);
    send_word(1'b1, 32'sd3, 32'sd0, 1'b0);
    send_word(1'b0, 32'sd0, 32'sd0, 1'b1);
    settle();
    write_reg(REG_RANK, 32'd2);
    cfg_write <= 1'b0;
    send_word(1'b1, 32'sd7, 32'sd0, 1'b0);
    send_word(1'b1, 32'sd7, 32'sd0, 1'b0);
    send_word(1'b1, 32'sd3, 32'sd0, 1'b1);

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct = 14;
          dst_idle_pct = 54;
        end
        1: begin
          src_idle_pct = 54;
          dst_idle_pct = 14;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      for (phase = 0; phase < 4; phase++) begin
        settle();
        program_random();
        counted = 0;
        while (counted < PHASE_WORDS) send_cloud(counted);
      end
    end
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS band_filtered_kth_farthest_unit");
    end else begin
      $display("FAIL band_filtered_kth_farthest_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL band_filtered_kth_farthest_unit");
    $finish;
  end

endmodule
